@@ sv/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the stress radial return block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define J2RR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define J2RR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/j2rr_pkg.sv @@
// Package with the types, constants and codes of the stress radial return block.
package j2rr_pkg;

  localparam int MAX_DIMS_DEF  = 3;
  localparam int FRAC_BITS_DEF = 20;

  localparam int STRESS_W = 40;
  localparam int YIELD_W  = 39;
  localparam int CNT_W    = 4;
  localparam int DT_W     = 32;

  // Widths of the shared iterative unit.
  localparam int AW = 88;
  localparam int BW = 48;
  localparam int QW = 88;

  localparam logic signed [STRESS_W-1:0] S_MAX = {1'b0, {(STRESS_W-1){1'b1}}};
  localparam logic signed [STRESS_W-1:0] S_MIN = {1'b1, {(STRESS_W-1){1'b0}}};

  localparam logic CFG_TIME_STEP = 1'b0;
  localparam logic CFG_DIMS      = 1'b1;

  typedef struct packed {
    logic signed [STRESS_W-1:0] prior_stress;
    logic signed [STRESS_W-1:0] rate_now;
    logic signed [STRESS_W-1:0] rate_initial;
    logic [YIELD_W-1:0]         yield_limit;
    logic                       final_component;
  } in_item_t;

  typedef struct packed {
    logic signed [STRESS_W-1:0] stress_out;
    logic [CNT_W-1:0]           component_index;
    logic                       was_yielded;
    logic                       last_of_tensor;
  } out_item_t;

  typedef enum logic [2:0] {
    U_HOLD,
    U_LOAD,
    U_MUL,
    U_DIV,
    U_SQRT
  } unit_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_STEP_MUL,
    S_STEP_ADD,
    S_SQ_RD,
    S_SQ_LOAD,
    S_SQ_MUL,
    S_SQ_ACC,
    S_Y_LOAD,
    S_Y_MUL,
    S_Y_CMP,
    S_SQRT,
    S_SQRT_END,
    S_SC_RD,
    S_SC_LOAD,
    S_SC_MUL,
    S_SC_DLOAD,
    S_SC_DIV,
    S_SC_END,
    S_EMIT
  } state_t;

endpackage

@@ sv/j2rr_unit.sv @@
// Shared iterative unit: shift-add multiply, restoring divide and square root steps.
module j2rr_unit import j2rr_pkg::*; (
  input  logic          clk,
  input  unit_op_t      op,
  input  logic [AW-1:0] ld_a,
  input  logic [BW-1:0] ld_b,
  input  logic [QW-1:0] ld_q,
  output logic [AW-1:0] a_o,
  output logic [BW-1:0] b_o,
  output logic [QW-1:0] q_o
);

  logic [AW-1:0] a_r, a_nxt;
  logic [BW-1:0] b_r, b_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [AW-1:0] x, y;
  logic          sub;
  logic [AW:0]   sum;
  logic          carry;

  // One adder serves every operation; for subtraction the carry means x >= y.
  always_comb begin
    x   = '0;
    y   = '0;
    sub = 1'b0;
    case (op)
      U_MUL: begin
        x = {a_r[AW-2:0], 1'b0};
        y = q_r[QW-1] ? AW'(b_r) : '0;
      end
      U_DIV: begin
        x   = {a_r[AW-2:0], q_r[QW-1]};
        y   = AW'(b_r);
        sub = 1'b1;
      end
      U_SQRT: begin
        x   = {a_r[AW-3:0], q_r[QW-1:QW-2]};
        y   = AW'({b_r, 2'b01});
        sub = 1'b1;
      end
      default: begin
        x = '0;
      end
    endcase
    sum   = {1'b0, x} + {1'b0, (sub ? ~y : y)} + (AW+1)'(sub);
    carry = sum[AW];
  end

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    q_nxt = q_r;
    case (op)
      U_LOAD: begin
        a_nxt = ld_a;
        b_nxt = ld_b;
        q_nxt = ld_q;
      end
      U_MUL: begin
        a_nxt = sum[AW-1:0];
        q_nxt = {q_r[QW-2:0], 1'b0};
      end
      U_DIV: begin
        a_nxt = carry ? sum[AW-1:0] : x;
        q_nxt = {q_r[QW-2:0], carry};
      end
      U_SQRT: begin
        a_nxt = carry ? sum[AW-1:0] : x;
        b_nxt = {b_r[BW-2:0], carry};
        q_nxt = {q_r[QW-3:0], 2'b00};
      end
      default: begin
        a_nxt = a_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    q_r <= q_nxt;
  end

  assign a_o = a_r;
  assign b_o = b_r;
  assign q_o = q_r;

endmodule

@@ sv/j2_stress_radial_return.sv @@
// Top level of the J2 radial return stress update: sequencer, component store and I/O.
//
// Usage: the host sends the stress components of one material point on the in_
// channel (valid/ready), one transfer per component in row-major order, with
// final_component set on the last one. Each component is advanced by a
// trapezoid step and kept in a small store. The transfer that completes the
// tensor starts the J2 check; the block then returns one out_ transfer per
// component, with component_index, was_yielded and last_of_tensor.
// Sequence: a component that does not complete the tensor is advanced by
// the 32-step serial multiply by time_step. Completing a tensor of n
// components then runs a squaring multiply per component, the yield square,
// and when the point yields the square root plus, per component, a multiply
// and the 80-step divide, all on the one shared unit. in_ready is high only
// while the block is idle.
// Reset (rst_n, synchronous) sets time_step to 0, dimension_count to 3 and
// clears the partial tensor count; the store needs no clearing. When the
// receiver stalls, the result is held in the output register until the
// transfer happens, and the block waits.
module j2_stress_radial_return import j2rr_pkg::*; #(
  parameter int MAX_DIMS  = MAX_DIMS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_data,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [DT_W-1:0] cfg_data
);

`include "assert_macros.svh"

  localparam int DEPTH = MAX_DIMS * MAX_DIMS;
  localparam int SA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [1:0] MAXD = 2'(MAX_DIMS);
  localparam logic [6:0] STEP_CYC = 7'(DT_W);
  localparam logic [6:0] SQ_CYC   = 7'(STRESS_W);
  localparam logic [6:0] Y_CYC    = 7'(YIELD_W);
  localparam logic [6:0] SQRT_CYC = 7'(QW / 2);
  localparam int NUM_W = STRESS_W + YIELD_W + 1;
  localparam logic [6:0] DIV_CYC  = 7'(NUM_W);
  localparam logic [AW-1:0] EPS = AW'(1) << (FRAC_BITS + 1);

  state_t state_r, state_nxt;
  logic [6:0]          cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    received_r, received_nxt;
  logic [DT_W-1:0]     time_step_r;
  logic [1:0]          dims_r;
  logic                yielded_r, yielded_nxt;
  logic [YIELD_W-1:0]  held_yield_r, held_yield_nxt;
  logic signed [STRESS_W-1:0] prior_r, prior_nxt;
  logic                neg_r, neg_nxt;
  logic                final_r, final_nxt;
  logic [YIELD_W-1:0]  yin_r, yin_nxt;
  logic [AW-1:0]       ssq_r, ssq_nxt;
  logic [AW-1:0]       t_r, t_nxt;
  logic [BW-1:0]       norm_r, norm_nxt;
  logic [STRESS_W-1:0] mag_r, mag_nxt;
  logic                sneg_r, sneg_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_r, out_nxt;

  logic signed [STRESS_W-1:0] store [DEPTH];
  logic signed [STRESS_W-1:0] rd_r;
  logic                store_we;
  logic [SA_W-1:0]     wr_addr;
  logic signed [STRESS_W-1:0] step_val;

  unit_op_t      u_op;
  logic [AW-1:0] u_ld_a, u_a;
  logic [BW-1:0] u_ld_b, u_b;
  logic [QW-1:0] u_ld_q, u_q;

  logic [1:0]          n_dim;
  logic [CNT_W-1:0]    nn;
  logic [CNT_W-1:0]    idx;
  logic signed [STRESS_W:0] rsum;
  logic [STRESS_W:0]   rmag;
  logic [73:0]         rnd;
  logic [42:0]         inc;
  logic signed [44:0]  s_wide;
  logic [STRESS_W-1:0] rd_mag;
  logic [NUM_W-1:0]    num;
  logic [STRESS_W:0]   quo;
  logic [STRESS_W-1:0] qm;

  j2rr_unit u_unit (
    .clk  (clk),
    .op   (u_op),
    .ld_a (u_ld_a),
    .ld_b (u_ld_b),
    .ld_q (u_ld_q),
    .a_o  (u_a),
    .b_o  (u_b),
    .q_o  (u_q)
  );

  // Out-of-range dimension counts are folded into the supported range.
  always_comb begin
    if (dims_r == 2'd0) begin
      n_dim = 2'd1;
    end else if (dims_r > MAXD) begin
      n_dim = MAXD;
    end else begin
      n_dim = dims_r;
    end
    nn  = CNT_W'(n_dim) * CNT_W'(n_dim);
    idx = (received_r >= CNT_W'(DEPTH)) ? CNT_W'(DEPTH - 1) : received_r;
  end

  // Trapezoid step arithmetic around the shared multiply.
  always_comb begin
    rsum   = (STRESS_W+1)'(in_data.rate_now) + (STRESS_W+1)'(in_data.rate_initial);
    rmag   = rsum[STRESS_W] ? (STRESS_W+1)'(-rsum) : (STRESS_W+1)'(rsum);
    rnd    = {1'b0, u_a[72:0]} + (74'(1) << 30);
    inc    = rnd[73:31];
    s_wide = neg_r ? (45'(prior_r) - $signed({2'b00, inc}))
                   : (45'(prior_r) + $signed({2'b00, inc}));
    if (s_wide > 45'(S_MAX)) begin
      step_val = S_MAX;
    end else if (s_wide < 45'(S_MIN)) begin
      step_val = S_MIN;
    end else begin
      step_val = s_wide[STRESS_W-1:0];
    end
    rd_mag = rd_r[STRESS_W-1] ? STRESS_W'(-rd_r) : STRESS_W'(rd_r);
    num    = u_a[NUM_W-1:0] + NUM_W'(norm_r >> 1);
    quo    = u_q[STRESS_W:0];
    qm     = (quo > (STRESS_W+1)'(mag_r)) ? mag_r : quo[STRESS_W-1:0];
  end

  assign wr_addr = idx[SA_W-1:0];

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[wr_addr] <= step_val;
    end
    rd_r <= store[k_r[SA_W-1:0]];
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    k_nxt          = k_r;
    count_nxt      = count_r;
    received_nxt   = received_r;
    yielded_nxt    = yielded_r;
    held_yield_nxt = held_yield_r;
    prior_nxt      = prior_r;
    neg_nxt        = neg_r;
    final_nxt      = final_r;
    yin_nxt        = yin_r;
    ssq_nxt        = ssq_r;
    t_nxt          = t_r;
    norm_nxt       = norm_r;
    mag_nxt        = mag_r;
    sneg_nxt       = sneg_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    store_we       = 1'b0;
    in_ready       = 1'b0;
    u_op           = U_HOLD;
    u_ld_a         = '0;
    u_ld_b         = '0;
    u_ld_q         = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          prior_nxt = in_data.prior_stress;
          neg_nxt   = rsum[STRESS_W];
          final_nxt = in_data.final_component;
          yin_nxt   = in_data.yield_limit;
          u_op      = U_LOAD;
          u_ld_b    = BW'(rmag);
          u_ld_q    = QW'(time_step_r) << (QW - DT_W);
          cnt_nxt   = STEP_CYC;
          state_nxt = S_STEP_MUL;
        end
      end
      S_STEP_MUL: begin
        u_op    = U_MUL;
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          state_nxt = S_STEP_ADD;
        end
      end
      S_STEP_ADD: begin
        store_we = 1'b1;
        if (final_r || ((idx + CNT_W'(1)) >= nn)) begin
          held_yield_nxt = yin_r;
          count_nxt      = idx + CNT_W'(1);
          received_nxt   = '0;
          k_nxt          = '0;
          ssq_nxt        = '0;
          state_nxt      = S_SQ_RD;
        end else begin
          received_nxt = idx + CNT_W'(1);
          state_nxt    = S_IDLE;
        end
      end
      S_SQ_RD: begin
        state_nxt = S_SQ_LOAD;
      end
      S_SQ_LOAD: begin
        u_op      = U_LOAD;
        u_ld_b    = BW'(rd_mag);
        u_ld_q    = QW'(rd_mag) << (QW - STRESS_W);
        cnt_nxt   = SQ_CYC;
        state_nxt = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        u_op    = U_MUL;
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          state_nxt = S_SQ_ACC;
        end
      end
      S_SQ_ACC: begin
        ssq_nxt = ssq_r + u_a;
        if ((k_r + CNT_W'(1)) == count_r) begin
          k_nxt     = '0;
          state_nxt = S_Y_LOAD;
        end else begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = S_SQ_RD;
        end
      end
      S_Y_LOAD: begin
        // 3*J2 + eps, scaled by two so that it stays an integer.
        t_nxt     = {ssq_r[AW-2:0], 1'b0} + ssq_r + EPS;
        u_op      = U_LOAD;
        u_ld_b    = BW'(held_yield_r);
        u_ld_q    = QW'(held_yield_r) << (QW - YIELD_W);
        cnt_nxt   = Y_CYC;
        state_nxt = S_Y_MUL;
      end
      S_Y_MUL: begin
        u_op    = U_MUL;
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          state_nxt = S_Y_CMP;
        end
      end
      S_Y_CMP: begin
        yielded_nxt = {u_a[AW-2:0], 1'b0} < t_r;
        if ({u_a[AW-2:0], 1'b0} < t_r) begin
          u_op      = U_LOAD;
          u_ld_q    = QW'(t_r >> 1);
          cnt_nxt   = SQRT_CYC;
          state_nxt = S_SQRT;
        end else begin
          state_nxt = S_SC_RD;
        end
      end
      S_SQRT: begin
        u_op    = U_SQRT;
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          state_nxt = S_SQRT_END;
        end
      end
      S_SQRT_END: begin
        norm_nxt  = u_b;
        state_nxt = S_SC_RD;
      end
      S_SC_RD: begin
        state_nxt = S_SC_LOAD;
      end
      S_SC_LOAD: begin
        mag_nxt  = rd_mag;
        sneg_nxt = rd_r[STRESS_W-1];
        if (yielded_r) begin
          u_op      = U_LOAD;
          u_ld_b    = BW'(rd_mag);
          u_ld_q    = QW'(held_yield_r) << (QW - YIELD_W);
          cnt_nxt   = Y_CYC;
          state_nxt = S_SC_MUL;
        end else begin
          out_nxt.stress_out      = rd_r;
          out_nxt.component_index = k_r;
          out_nxt.was_yielded     = 1'b0;
          out_nxt.last_of_tensor  = (k_r + CNT_W'(1)) == count_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = S_EMIT;
        end
      end
      S_SC_MUL: begin
        u_op    = U_MUL;
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          state_nxt = S_SC_DLOAD;
        end
      end
      S_SC_DLOAD: begin
        // Rounded quotient: add half the divisor before the divide.
        u_op      = U_LOAD;
        u_ld_b    = norm_r;
        u_ld_q    = QW'(num) << (QW - NUM_W);
        cnt_nxt   = DIV_CYC;
        state_nxt = S_SC_DIV;
      end
      S_SC_DIV: begin
        u_op    = U_DIV;
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          state_nxt = S_SC_END;
        end
      end
      S_SC_END: begin
        out_nxt.stress_out      = sneg_r ? STRESS_W'(-$signed(qm)) : $signed(qm);
        out_nxt.component_index = k_r;
        out_nxt.was_yielded     = 1'b1;
        out_nxt.last_of_tensor  = (k_r + CNT_W'(1)) == count_r;
        out_valid_nxt           = 1'b1;
        state_nxt               = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_r.last_of_tensor) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + CNT_W'(1);
            state_nxt = S_SC_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      k_r          <= '0;
      count_r      <= '0;
      received_r   <= '0;
      yielded_r    <= 1'b0;
      held_yield_r <= '0;
      out_valid_r  <= 1'b0;
      time_step_r  <= '0;
      dims_r       <= 2'd3;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      k_r          <= k_nxt;
      count_r      <= count_nxt;
      received_r   <= received_nxt;
      yielded_r    <= yielded_nxt;
      held_yield_r <= held_yield_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIME_STEP: time_step_r <= cfg_data;
          CFG_DIMS:      dims_r      <= cfg_data[1:0];
          default:       dims_r      <= dims_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prior_r <= prior_nxt;
    neg_r   <= neg_nxt;
    final_r <= final_nxt;
    yin_r   <= yin_nxt;
    ssq_r   <= ssq_nxt;
    t_r     <= t_nxt;
    norm_r  <= norm_nxt;
    mag_r   <= mag_nxt;
    sneg_r  <= sneg_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The block never takes an item while a result is pending.
  `J2RR_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "input taken while result pending")
  // After the last result of a tensor the block is idle again.
  `J2RR_ASSERT_NEXT(a_last_idle, out_valid && out_ready && out_data.last_of_tensor, in_ready,
    "block not idle after last result")
  // The partial tensor count never exceeds the store depth.
  `J2RR_ASSERT_NOW(a_count_range, 1'b1, received_r <= CNT_W'(DEPTH), "component count overflow")

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the J2 radial return stress update block.
`timescale 1ns / 1ps

module testbench;
  import j2rr_pkg::*;

  // Generous cycle budget. The slowest correct run is about fifteen yielding
  // nine-component points, plus receiver stalls.
  localparam int CYCLE_LIMIT = 600000;
  localparam int STALL_LEN   = 400;
  localparam int SETTLE      = 80;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  in_item_t        in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_item_t       out_data;
  logic            cfg_we = 1'b0;
  logic            cfg_index = CFG_TIME_STEP;
  logic [DT_W-1:0] cfg_data = '0;

  j2_stress_radial_return dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Stimulus waiting to be offered, and the stress components expected back.
  in_item_t  pending_items[$];
  out_item_t expected_stress[$];

  // Shadow copy of the block's registers and tensor state.
  logic [31:0]         shadow_dt = '0;
  logic [1:0]          shadow_dims = 2'd3;
  logic signed [39:0]  tensor_store[9];
  int unsigned         tensor_count = 0;

  int  send_idle = 18;
  int  recv_idle = 65;
  bit  stall_req = 1'b0;
  int  stall_done = 0;
  int  error_count = 0;
  int  cycle_count = 0;

  // Trapezoid step: prior + dt/2 * (rate_now + rate_initial), with the
  // increment magnitude rounded half away from zero, then saturated.
  function automatic logic signed [39:0] advance_component(logic signed [39:0] prior,
      logic signed [39:0] rn, logic signed [39:0] ri);
    longint      sum;
    longint      s;
    logic [127:0] mag;
    logic [127:0] inc;
    sum = longint'(rn) + longint'(ri);
    mag = (sum < 0) ? 128'(-sum) : 128'(sum);
    inc = (mag * 128'(shadow_dt) + (128'd1 << 30)) >> 31;
    s = (sum < 0) ? longint'(prior) - longint'(inc) : longint'(prior) + longint'(inc);
    if (s > longint'(S_MAX)) s = longint'(S_MAX);
    if (s < longint'(S_MIN)) s = longint'(S_MIN);
    return s[39:0];
  endfunction

  // Closes the tensor: yield test against 3*J2 + eps and radial return.
  task automatic close_tensor(int unsigned count, logic [38:0] yield_lim);
    logic [127:0] sum_sq;
    logic [127:0] three_j2;
    logic [127:0] yield_sq;
    logic [127:0] half;
    logic [127:0] cand;
    logic [127:0] norm;
    logic [127:0] mag;
    logic [127:0] quo;
    logic         yielded;
    out_item_t    res;
    sum_sq = '0;
    norm = 128'd1;
    for (int k = 0; k < count; k++) begin
      mag = (tensor_store[k] < 0) ? 128'(-longint'(tensor_store[k])) : 128'(tensor_store[k]);
      sum_sq += mag * mag;
    end
    three_j2 = 3 * sum_sq + (128'd1 << 21);
    yield_sq = 2 * (128'(yield_lim) * 128'(yield_lim));
    yielded = yield_sq < three_j2;
    if (yielded) begin
      half = three_j2 >> 1;
      norm = '0;
      for (int b = 47; b >= 0; b--) begin
        cand = norm | (128'd1 << b);
        if (cand * cand <= half) norm = cand;
      end
      if (norm == 0) norm = 128'd1;
    end
    for (int k = 0; k < count; k++) begin
      res.stress_out = tensor_store[k];
      if (yielded) begin
        mag = (tensor_store[k] < 0) ? 128'(-longint'(tensor_store[k])) : 128'(tensor_store[k]);
        quo = (mag * 128'(yield_lim) + (norm >> 1)) / norm;
        if (quo > mag) quo = mag;
        res.stress_out = (tensor_store[k] < 0) ? -quo[39:0] : quo[39:0];
      end
      res.component_index = k[3:0];
      res.was_yielded = yielded;
      res.last_of_tensor = (k + 1 == count);
      expected_stress.push_back(res);
    end
  endtask

  // Accepted component: store it and close the tensor when it is complete.
  task automatic predict_transfer(in_item_t item);
    int unsigned dims;
    int unsigned slot;
    dims = (shadow_dims < 1) ? 1 : shadow_dims;
    slot = (tensor_count >= 9) ? 8 : tensor_count;
    tensor_store[slot] = advance_component(item.prior_stress, item.rate_now, item.rate_initial);
    tensor_count = slot + 1;
    if (item.final_component || tensor_count >= dims * dims) begin
      close_tensor(tensor_count, item.yield_limit);
      tensor_count = 0;
    end
  endtask

  // Sender: a new item is offered only once the previous one has been
  // transferred, so valid and payload hold steady until accepted.
  always @(posedge clk) begin
    if (rst_n && (!in_valid || in_ready)) begin
      if (in_valid) predict_transfer(in_data);
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_valid <= 1'b1;
        in_data <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks every result transfer against the oldest expectation,
  // then picks its ready for the next cycle. A requested long hold-off keeps
  // ready low for a counted stretch so the block backs up into its input.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_stress.size() == 0) begin
          $error("unexpected result: stress_out %0d index %0d",
                 out_data.stress_out, out_data.component_index);
          error_count++;
        end else begin
          out_item_t want;
          want = expected_stress.pop_front();
          if (out_data.stress_out !== want.stress_out) begin
            $error("stress_out: expected %0d, got %0d", want.stress_out, out_data.stress_out);
            error_count++;
          end
          if (out_data.component_index !== want.component_index) begin
            $error("component_index: expected %0d, got %0d",
                   want.component_index, out_data.component_index);
            error_count++;
          end
          if (out_data.was_yielded !== want.was_yielded) begin
            $error("was_yielded: expected %0b, got %0b", want.was_yielded, out_data.was_yielded);
            error_count++;
          end
          if (out_data.last_of_tensor !== want.last_of_tensor) begin
            $error("last_of_tensor: expected %0b, got %0b",
                   want.last_of_tensor, out_data.last_of_tensor);
            error_count++;
          end
        end
      end
      if (stall_req && stall_done < STALL_LEN) begin
        stall_done++;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Random stress value: mostly moderate magnitudes where the yield test is
  // interesting, sometimes the full 40-bit range to hit saturation.
  function automatic logic signed [39:0] random_stress();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    if ($urandom_range(3) == 0) return raw[39:0];
    return 40'($signed(raw[29:0])) >>> $urandom_range(8);
  endfunction

  function automatic logic [38:0] random_yield();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return raw[38:0];
      1: return 39'(raw[31:0] >> $urandom_range(16));
      default: return 39'(raw[29:0]);
    endcase
  endfunction

  function automatic in_item_t make_item(logic signed [39:0] prior, logic signed [39:0] rn,
      logic signed [39:0] ri, logic [38:0] yl, logic fin);
    in_item_t item;
    item.prior_stress = prior;
    item.rate_now = rn;
    item.rate_initial = ri;
    item.yield_limit = yl;
    item.final_component = fin;
    return item;
  endfunction

  // Queues one tensor of random content. Most are well formed; some end
  // early, some omit the final mark, and some carry marks at random.
  task automatic queue_tensor(inout int queued);
    int unsigned dims;
    int unsigned len;
    int          shape;
    logic        fin;
    dims = (shadow_dims < 1) ? 1 : shadow_dims;
    len = dims * dims;
    shape = $urandom_range(9);
    if (shape <= 1) len = $urandom_range(dims * dims);
    if (len == 0) len = 1;
    for (int k = 0; k < len; k++) begin
      case (shape)
        0: fin = $urandom_range(3) == 0;
        2: fin = 1'b0;
        default: fin = (k == len - 1);
      endcase
      pending_items.push_back(make_item(random_stress(), random_stress(), random_stress(),
                                        random_yield(), fin));
      queued++;
    end
  endtask

  // Sender pause: wait until everything offered has been transferred and
  // every expected result has come back, then let in-flight work settle.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_stress.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == CFG_TIME_STEP) shadow_dt = value;
    else shadow_dims = value[1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(logic [31:0] dt, logic [1:0] dims, int s_idle, int r_idle,
      bit long_stall);
    int queued;
    queued = 0;
    drain();
    write_reg(CFG_TIME_STEP, dt);
    write_reg(CFG_DIMS, {30'd0, dims});
    send_idle = s_idle;
    recv_idle = r_idle;
    while (queued < 24) queue_tensor(queued);
    if (long_stall) stall_req = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, full-scale time step and the reset dimension count.
    write_reg(CFG_TIME_STEP, 32'hFFFF_FFFF);
    // Positive and negative saturation, then zero yield so every component
    // is returned to zero.
    pending_items.push_back(make_item(S_MAX, S_MAX, S_MAX, '0, 1'b0));
    pending_items.push_back(make_item(S_MIN, S_MIN, S_MIN, '0, 1'b0));
    for (int k = 2; k < 9; k++)
      pending_items.push_back(make_item(random_stress(), random_stress(), random_stress(),
                                        '0, k == 8));
    drain();
    // One-by-one tensor with the largest yield and no final mark.
    write_reg(CFG_DIMS, 32'd1);
    pending_items.push_back(make_item(40'sd5 << 20, -40'sd3 << 20, 40'sd1, {39{1'b1}}, 1'b0));
    drain();
    // Two by two: an early final mark, then a full tensor with the largest yield.
    write_reg(CFG_DIMS, 32'd2);
    pending_items.push_back(make_item(-40'sd7 << 20, 40'sd2 << 20, 40'sd0, 39'd100, 1'b0));
    pending_items.push_back(make_item(40'sd9 << 20, 40'sd0, -40'sd1, 39'd100, 1'b1));
    for (int k = 0; k < 4; k++)
      pending_items.push_back(make_item(random_stress(), random_stress(), random_stress(),
                                        {39{1'b1}}, k == 3));
    drain();
    // A dimension count of zero behaves as one.
    write_reg(CFG_DIMS, 32'd0);
    pending_items.push_back(make_item(S_MIN, S_MAX, S_MIN, 39'd1, 1'b0));
    drain();
    // Zero time step; leave four components of a three by three tensor open
    // so the next phase's smaller count completes it on its next component.
    write_reg(CFG_TIME_STEP, 32'd0);
    write_reg(CFG_DIMS, 32'd3);
    for (int k = 0; k < 4; k++)
      pending_items.push_back(make_item(random_stress(), random_stress(), random_stress(),
                                        random_yield(), 1'b0));

    // Random phases with the idling mixes; the receiver hold-off lands at
    // the start of the second phase while the sender keeps offering.
    run_phase($urandom, 2'd2, 18, 65, 1'b0);
    run_phase($urandom, 2'd3, 65, 18, 1'b1);
    run_phase(32'h4000_0000, 2'd1, 0, 0, 1'b0);
    run_phase($urandom, 2'd3, 0, 0, 1'b0);

    drain();
    if (error_count == 0 && expected_stress.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ j2_stress_radial_return.f @@
+incdir+sv
sv/j2rr_pkg.sv
sv/j2rr_unit.sv
sv/j2_stress_radial_return.sv
verif/testbench.sv
